// File: src/pd_position_thrust_controller_top_defines.svh
// assertion macros shared by the checker of the position thrust controller
// no dependencies; included by the checker file
`ifndef PD_POSITION_THRUST_CONTROLLER_TOP_DEFINES_SVH
`define PD_POSITION_THRUST_CONTROLLER_TOP_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define PTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent checked in the same cycle as the antecedent
`define PTC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: src/ptc_pkg.sv
// types, widths and the step program of the position thrust controller
// no dependencies; imported by the controller, the datapath and the top level
package ptc_pkg;

   localparam int DATA_W      = 32;
   localparam int GAIN_W      = 16;
   localparam int QUAT_W      = 16;
   localparam int ERR_W       = 33;
   localparam int RM_W        = 22;
   localparam int MUL_A_W     = 22;
   localparam int MUL_B_W     = 33;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = 60;
   localparam int CSR_ADDR_W  = 3;
   localparam int REQ_TDATA_W = 264;
   localparam int RSP_TDATA_W = 96;
   localparam int IDX_W       = 4;
   localparam int STEP_COUNT  = 39;
   localparam int STEP_W      = 6;
   localparam int FLUSH_CYCLES = 2;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_P_X = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_P_Y = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_P_Z = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_D_X = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_D_Y = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_D_Z = 3'd5;

   // operand indexes
   localparam logic [IDX_W-1:0] AX_X = 4'd0;
   localparam logic [IDX_W-1:0] AX_Y = 4'd1;
   localparam logic [IDX_W-1:0] AX_Z = 4'd2;
   localparam logic [IDX_W-1:0] IDX_QW = 4'd0;
   localparam logic [IDX_W-1:0] IDX_QI = 4'd1;
   localparam logic [IDX_W-1:0] IDX_QJ = 4'd2;
   localparam logic [IDX_W-1:0] IDX_QK = 4'd3;
   localparam logic [IDX_W-1:0] RM_00 = 4'd0;
   localparam logic [IDX_W-1:0] RM_01 = 4'd1;
   localparam logic [IDX_W-1:0] RM_02 = 4'd2;
   localparam logic [IDX_W-1:0] RM_10 = 4'd3;
   localparam logic [IDX_W-1:0] RM_11 = 4'd4;
   localparam logic [IDX_W-1:0] RM_12 = 4'd5;
   localparam logic [IDX_W-1:0] RM_20 = 4'd6;
   localparam logic [IDX_W-1:0] RM_21 = 4'd7;
   localparam logic [IDX_W-1:0] RM_22 = 4'd8;

   typedef enum logic [1:0] {A_KP, A_KD, A_QUAT, A_RM} a_sel_type;
   typedef enum logic [1:0] {B_ERR, B_VEL, B_QUAT, B_WORLD} b_sel_type;
   typedef enum logic [2:0] {
      ACC_SET, ACC_ADD, ACC_SUB, ACC_SET2, ACC_ADD2, ACC_SUB2
   } acc_op_type;
   typedef enum logic [1:0] {WB_NONE, WB_WORLD, WB_RM, WB_BODY} wb_sel_type;
   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH, ST_PUSH} ctrl_state_type;

   typedef struct packed {
      logic              issue;
      a_sel_type         a_sel;
      logic [IDX_W-1:0]  a_idx;
      b_sel_type         b_sel;
      logic [IDX_W-1:0]  b_idx;
      acc_op_type        acc_op;
      wb_sel_type        wb_sel;
      logic [IDX_W-1:0]  wb_idx;
   } step_type;

   typedef struct packed {
      logic     capture;
      logic     load_target;
      logic     push;
      step_type step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   function automatic step_type st(input a_sel_type a_sel, input logic [IDX_W-1:0] a_idx,
                                   input b_sel_type b_sel, input logic [IDX_W-1:0] b_idx,
                                   input acc_op_type op, input wb_sel_type wb,
                                   input logic [IDX_W-1:0] wb_idx);
      step_type s;
      s.issue  = 1'b1;
      s.a_sel  = a_sel;
      s.a_idx  = a_idx;
      s.b_sel  = b_sel;
      s.b_idx  = b_idx;
      s.acc_op = op;
      s.wb_sel = wb;
      s.wb_idx = wb_idx;
      return s;
   endfunction

   // one multiply per step: world terms, rotation matrix, then body vector
   function automatic step_type step_lookup(input logic [STEP_W-1:0] idx);
      step_type s;
      s = '0;
      case (idx)
         6'd0:  s = st(A_KP, AX_X, B_ERR, AX_X, ACC_SET, WB_NONE, AX_X);
         6'd1:  s = st(A_KD, AX_X, B_VEL, AX_X, ACC_SUB, WB_WORLD, AX_X);
         6'd2:  s = st(A_KP, AX_Y, B_ERR, AX_Y, ACC_SET, WB_NONE, AX_Y);
         6'd3:  s = st(A_KD, AX_Y, B_VEL, AX_Y, ACC_SUB, WB_WORLD, AX_Y);
         6'd4:  s = st(A_KP, AX_Z, B_ERR, AX_Z, ACC_SET, WB_NONE, AX_Z);
         6'd5:  s = st(A_KD, AX_Z, B_VEL, AX_Z, ACC_SUB, WB_WORLD, AX_Z);
         // r00 = ww + ii - jj - kk
         6'd6:  s = st(A_QUAT, IDX_QW, B_QUAT, IDX_QW, ACC_SET, WB_NONE, RM_00);
         6'd7:  s = st(A_QUAT, IDX_QI, B_QUAT, IDX_QI, ACC_ADD, WB_NONE, RM_00);
         6'd8:  s = st(A_QUAT, IDX_QJ, B_QUAT, IDX_QJ, ACC_SUB, WB_NONE, RM_00);
         6'd9:  s = st(A_QUAT, IDX_QK, B_QUAT, IDX_QK, ACC_SUB, WB_RM, RM_00);
         // r01 = 2(ij - wk)
         6'd10: s = st(A_QUAT, IDX_QI, B_QUAT, IDX_QJ, ACC_SET2, WB_NONE, RM_01);
         6'd11: s = st(A_QUAT, IDX_QW, B_QUAT, IDX_QK, ACC_SUB2, WB_RM, RM_01);
         // r02 = 2(ik + wj)
         6'd12: s = st(A_QUAT, IDX_QI, B_QUAT, IDX_QK, ACC_SET2, WB_NONE, RM_02);
         6'd13: s = st(A_QUAT, IDX_QW, B_QUAT, IDX_QJ, ACC_ADD2, WB_RM, RM_02);
         // r10 = 2(ij + wk)
         6'd14: s = st(A_QUAT, IDX_QI, B_QUAT, IDX_QJ, ACC_SET2, WB_NONE, RM_10);
         6'd15: s = st(A_QUAT, IDX_QW, B_QUAT, IDX_QK, ACC_ADD2, WB_RM, RM_10);
         // r11 = ww - ii + jj - kk
         6'd16: s = st(A_QUAT, IDX_QW, B_QUAT, IDX_QW, ACC_SET, WB_NONE, RM_11);
         6'd17: s = st(A_QUAT, IDX_QI, B_QUAT, IDX_QI, ACC_SUB, WB_NONE, RM_11);
         6'd18: s = st(A_QUAT, IDX_QJ, B_QUAT, IDX_QJ, ACC_ADD, WB_NONE, RM_11);
         6'd19: s = st(A_QUAT, IDX_QK, B_QUAT, IDX_QK, ACC_SUB, WB_RM, RM_11);
         // r12 = 2(jk - wi)
         6'd20: s = st(A_QUAT, IDX_QJ, B_QUAT, IDX_QK, ACC_SET2, WB_NONE, RM_12);
         6'd21: s = st(A_QUAT, IDX_QW, B_QUAT, IDX_QI, ACC_SUB2, WB_RM, RM_12);
         // r20 = 2(ik - wj)
         6'd22: s = st(A_QUAT, IDX_QI, B_QUAT, IDX_QK, ACC_SET2, WB_NONE, RM_20);
         6'd23: s = st(A_QUAT, IDX_QW, B_QUAT, IDX_QJ, ACC_SUB2, WB_RM, RM_20);
         // r21 = 2(jk + wi)
         6'd24: s = st(A_QUAT, IDX_QJ, B_QUAT, IDX_QK, ACC_SET2, WB_NONE, RM_21);
         6'd25: s = st(A_QUAT, IDX_QW, B_QUAT, IDX_QI, ACC_ADD2, WB_RM, RM_21);
         // r22 = ww - ii - jj + kk
         6'd26: s = st(A_QUAT, IDX_QW, B_QUAT, IDX_QW, ACC_SET, WB_NONE, RM_22);
         6'd27: s = st(A_QUAT, IDX_QI, B_QUAT, IDX_QI, ACC_SUB, WB_NONE, RM_22);
         6'd28: s = st(A_QUAT, IDX_QJ, B_QUAT, IDX_QJ, ACC_SUB, WB_NONE, RM_22);
         6'd29: s = st(A_QUAT, IDX_QK, B_QUAT, IDX_QK, ACC_ADD, WB_RM, RM_22);
         // body[n] = sum over m of r[m][n] * world[m]
         6'd30: s = st(A_RM, RM_00, B_WORLD, AX_X, ACC_SET, WB_NONE, AX_X);
         6'd31: s = st(A_RM, RM_10, B_WORLD, AX_Y, ACC_ADD, WB_NONE, AX_X);
         6'd32: s = st(A_RM, RM_20, B_WORLD, AX_Z, ACC_ADD, WB_BODY, AX_X);
         6'd33: s = st(A_RM, RM_01, B_WORLD, AX_X, ACC_SET, WB_NONE, AX_Y);
         6'd34: s = st(A_RM, RM_11, B_WORLD, AX_Y, ACC_ADD, WB_NONE, AX_Y);
         6'd35: s = st(A_RM, RM_21, B_WORLD, AX_Z, ACC_ADD, WB_BODY, AX_Y);
         6'd36: s = st(A_RM, RM_02, B_WORLD, AX_X, ACC_SET, WB_NONE, AX_Z);
         6'd37: s = st(A_RM, RM_12, B_WORLD, AX_Y, ACC_ADD, WB_NONE, AX_Z);
         6'd38: s = st(A_RM, RM_22, B_WORLD, AX_Z, ACC_ADD, WB_BODY, AX_Z);
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

// File: src/pd_position_thrust_controller_top.sv
// top level of the pd position thrust controller; depends on ptc_pkg, ptc_ctrl, ptc_datapath
// a setpoint load produces no result
// a measurement runs 39 steps on one shared 22x33 multiplier, then flush and push states;
// the push waits while a held result is not taken, and rsp_tvalid rises after the push
// req_tready stays low from the acceptance of a measurement until its push
// synchronous active-high reset: gains p=1.0, d=0, target zero, no result pending
module pd_position_thrust_controller_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ptc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [ptc_pkg::GAIN_W-1:0]         csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, quat_w, quat_i, quat_j, quat_k,
   // altitude_only, zero fill
   input  logic [ptc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_type
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // thrust_x, thrust_y, thrust_z
   output logic [ptc_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import ptc_pkg::*;

   logic signed [DATA_W-1:0] pos [3];
   logic signed [DATA_W-1:0] vel [3];
   logic signed [QUAT_W-1:0] quat [4];
   logic signed [DATA_W-1:0] thrust [3];
   logic                     altitude_only;
   ctrl_cmd_type             cmd;
   dp_status_type            status;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pos[a] = req_tdata[a*DATA_W +: DATA_W];
         vel[a] = req_tdata[(a+3)*DATA_W +: DATA_W];
      end
      for (int q = 0; q < 4; q++)
         quat[q] = req_tdata[6*DATA_W + q*QUAT_W +: QUAT_W];
      altitude_only = req_tdata[6*DATA_W + 4*QUAT_W];
   end

   ptc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_meas  (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ptc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .pos           (pos),
      .vel           (vel),
      .quat          (quat),
      .altitude_only (altitude_only),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .thrust        (thrust)
   );

   assign rsp_tdata = {thrust[2], thrust[1], thrust[0]};

endmodule

// File: src/ptc_ctrl.sv
// sequencer of the position thrust controller: walks the step program
// depends on ptc_pkg
module ptc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_meas,
   output logic                   req_ready,
   input  ptc_pkg::dp_status_type status,
   output ptc_pkg::ctrl_cmd_type  cmd
);
   import ptc_pkg::*;

   ctrl_state_type     state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            step_in   = '0;
            if (req_valid) begin
               if (req_meas) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_RUN;
               end else begin
                  cmd.load_target = 1'b1;
               end
            end
         end
         ST_RUN: begin
            cmd.step = step_lookup(step_ff);
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEP_COUNT - 1)) begin
               step_in  = '0;
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // let the multiply, accumulate and write-back stages finish the last body term
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(FLUSH_CYCLES - 1)) begin
               step_in  = '0;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: src/ptc_datapath.sv
// datapath of the position thrust controller: gains, target, shared multiplier,
// accumulator, world vector, rotation matrix and output register; depends on ptc_pkg
module ptc_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [ptc_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic [ptc_pkg::GAIN_W-1:0]             csr_wdata,
   input  logic signed [ptc_pkg::DATA_W-1:0]      pos [3],
   input  logic signed [ptc_pkg::DATA_W-1:0]      vel [3],
   input  logic signed [ptc_pkg::QUAT_W-1:0]      quat [4],
   input  logic                                   altitude_only,
   input  ptc_pkg::ctrl_cmd_type                  cmd,
   output ptc_pkg::dp_status_type                 status,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic signed [ptc_pkg::DATA_W-1:0]      thrust [3]
);
   import ptc_pkg::*;

   localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-31){1'b1}}, 31'd0};
   localparam logic signed [ACC_W-1:0] HALF_WORLD = ACC_W'(128);
   localparam logic signed [ACC_W-1:0] HALF_RM    = ACC_W'(2048);
   localparam logic signed [ACC_W-1:0] HALF_BODY  = ACC_W'(32768);

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > SAT_MAX)
         r = SAT_MAX[DATA_W-1:0];
      else if (x < SAT_MIN)
         r = SAT_MIN[DATA_W-1:0];
      else
         r = x[DATA_W-1:0];
      return r;
   endfunction

   logic [GAIN_W-1:0]           gain_p_ff [3];
   logic [GAIN_W-1:0]           gain_d_ff [3];
   logic signed [DATA_W-1:0]    target_ff [3];
   logic signed [ERR_W-1:0]     err_ff [3];
   logic signed [DATA_W-1:0]    vel_ff [3];
   logic signed [QUAT_W-1:0]    quat_ff [4];
   logic                        alt_ff;
   logic signed [DATA_W-1:0]    world_ff [3];
   logic signed [RM_W-1:0]      rm_ff [9];
   logic signed [DATA_W-1:0]    body_ff [3];
   logic signed [DATA_W-1:0]    thrust_ff [3];
   logic                        rsp_valid_ff;

   logic signed [MUL_A_W-1:0]   op_a;
   logic signed [MUL_B_W-1:0]   op_b;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [ACC_W-1:0]     prod_ext, prod_dbl;

   logic                        s1_valid_ff, s2_valid_ff;
   acc_op_type                  s1_op_ff;
   wb_sel_type                  s1_wb_ff, s2_wb_ff;
   logic [IDX_W-1:0]            s1_idx_ff, s2_idx_ff;

   logic signed [ACC_W-1:0]     world_shift, rm_shift, body_shift;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            gain_p_ff[a] <= GAIN_W'(256);
            gain_d_ff[a] <= '0;
         end
      end else if (csr_we) begin
         case (csr_addr)
            CSR_GAIN_P_X: gain_p_ff[0] <= csr_wdata;
            CSR_GAIN_P_Y: gain_p_ff[1] <= csr_wdata;
            CSR_GAIN_P_Z: gain_p_ff[2] <= csr_wdata;
            CSR_GAIN_D_X: gain_d_ff[0] <= csr_wdata;
            CSR_GAIN_D_Y: gain_d_ff[1] <= csr_wdata;
            CSR_GAIN_D_Z: gain_d_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++)
            target_ff[a] <= '0;
      end else if (cmd.load_target) begin
         for (int a = 0; a < 3; a++)
            target_ff[a] <= pos[a];
      end
   end

   // measurement capture, error formed once at full width
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int a = 0; a < 3; a++) begin
            err_ff[a] <= {target_ff[a][DATA_W-1], target_ff[a]} - {pos[a][DATA_W-1], pos[a]};
            vel_ff[a] <= vel[a];
         end
         for (int q = 0; q < 4; q++)
            quat_ff[q] <= quat[q];
         alt_ff <= altitude_only;
      end
   end

   always_comb begin
      unique case (cmd.step.a_sel)
         A_KP:   op_a = MUL_A_W'({1'b0, gain_p_ff[cmd.step.a_idx[1:0]]});
         A_KD:   op_a = MUL_A_W'({1'b0, gain_d_ff[cmd.step.a_idx[1:0]]});
         A_QUAT: op_a = MUL_A_W'(quat_ff[cmd.step.a_idx[1:0]]);
         A_RM:   op_a = rm_ff[cmd.step.a_idx];
         default: op_a = '0;
      endcase
      unique case (cmd.step.b_sel)
         B_ERR:   op_b = err_ff[cmd.step.b_idx[1:0]];
         B_VEL:   op_b = MUL_B_W'(vel_ff[cmd.step.b_idx[1:0]]);
         B_QUAT:  op_b = MUL_B_W'(quat_ff[cmd.step.b_idx[1:0]]);
         B_WORLD: op_b = MUL_B_W'(world_ff[cmd.step.b_idx[1:0]]);
         default: op_b = '0;
      endcase
      prod_in = op_a * op_b;
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (cmd.step.issue)
         prod_ff <= prod_in;
      s1_op_ff  <= cmd.step.acc_op;
      s1_wb_ff  <= cmd.step.wb_sel;
      s1_idx_ff <= cmd.step.wb_idx;
   end

   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      prod_dbl = prod_ext <<< 1;
      case (s1_op_ff)
         ACC_SET:  acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         ACC_SET2: acc_in = prod_dbl;
         ACC_ADD2: acc_in = acc_ff + prod_dbl;
         ACC_SUB2: acc_in = acc_ff - prod_dbl;
         default:  acc_in = acc_ff;
      endcase
   end

   // accumulate stage
   always_ff @(posedge clock) begin
      if (s1_valid_ff)
         acc_ff <= acc_in;
      s2_wb_ff  <= s1_wb_ff;
      s2_idx_ff <= s1_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.step.issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // rounding to q16 with floor shift
   always_comb begin
      world_shift = (acc_ff + HALF_WORLD) >>> 8;
      rm_shift    = (acc_ff + HALF_RM) >>> 12;
      body_shift  = (acc_ff + HALF_BODY) >>> 16;
   end

   // write-back stage
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         unique case (s2_wb_ff)
            WB_NONE: ;
            WB_WORLD: begin
               if (alt_ff && (s2_idx_ff != AX_Z))
                  world_ff[s2_idx_ff[1:0]] <= '0;
               else
                  world_ff[s2_idx_ff[1:0]] <= sat32(world_shift);
            end
            WB_RM:   rm_ff[s2_idx_ff] <= rm_shift[RM_W-1:0];
            WB_BODY: body_ff[s2_idx_ff[1:0]] <= sat32(body_shift);
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         for (int a = 0; a < 3; a++)
            thrust_ff[a] <= body_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.push)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign thrust          = thrust_ff;

endmodule

// File: src/ptc_checker.sv
// port-level checks of the pd position thrust controller, bound to the top level
// depends on pd_position_thrust_controller_top_defines.svh
`include "pd_position_thrust_controller_top_defines.svh"

module ptc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   `PTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped or changed while stalled")

   `PTC_ASSERT_NEXT(a_meas_busy, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready, "measurement accepted but block not busy")

   `PTC_ASSERT_NEXT(a_load_quick, clock, reset, req_tvalid && req_tready && !req_tuser, req_tready, "setpoint load did not finish in one cycle")

   `PTC_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_tvalid, "result valid right after reset")

   `PTC_ASSERT_SAME(a_push_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result appeared while idle")

endmodule

bind pd_position_thrust_controller_top ptc_checker u_ptc_checker (.*);
